### rtl/kmsd_pkg.sv
// Shared types and constants for the keypad matrix scanner and debouncer.
package kmsd_pkg;

  localparam int unsigned ROWS_DEF    = 4;
  localparam int unsigned COLUMNS_DEF = 2;

  localparam int unsigned SETTLE_W   = 8;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = 8'd1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE_TICKS   = 4'd0,
    CFG_DEBOUNCE_TICKS = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic changed;
    logic pressed;
    logic released;
  } key_flags_t;

endpackage

### rtl/kmsd_scan.sv
// Column scanner: column drive, settle counter and per-scan raw code assembly.
module kmsd_scan #(
  parameter int unsigned ROWS    = kmsd_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = kmsd_pkg::COLUMNS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [ROWS-1:0]             row_levels_i,
  input  logic [kmsd_pkg::SETTLE_W-1:0] settle_ticks_i,
  output logic [COLUMNS-1:0]          column_drive_o,
  output logic                        done_o,
  output logic [ROWS*COLUMNS-1:0]     code_o
);
  import kmsd_pkg::*;

  localparam int unsigned CODE_W = ROWS * COLUMNS;
  localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  logic [COL_W-1:0]    col_q, col_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  logic [CODE_W-1:0]   partial_q, partial_d;

  logic [SETTLE_W-1:0] need;
  logic [SETTLE_W-1:0] count_inc;
  logic                sample;
  logic [ROWS-1:0]     top_row;
  logic [CODE_W-1:0]   code;

  // Keep only the highest pressed row.
  always_comb begin
    top_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (!row_levels_i[r]) begin
        top_row    = '0;
        top_row[r] = 1'b1;
      end
    end
  end

  always_comb begin
    need      = (settle_ticks_i == '0) ? SETTLE_W'(1) : settle_ticks_i;
    count_inc = settle_q + SETTLE_W'(1);
    sample    = (count_inc >= need);

    column_drive_o = '1;
    code           = partial_q;
    for (int c = 0; c < COLUMNS; c++) begin
      if (col_q == COL_W'(c)) begin
        column_drive_o[c]         = 1'b0;
        code[c*ROWS +: ROWS]      = partial_q[c*ROWS +: ROWS] | top_row;
      end
    end

    done_o    = 1'b0;
    col_d     = col_q;
    partial_d = partial_q;
    settle_d  = count_inc;
    if (sample) begin
      settle_d = '0;
      if (col_q == LAST_COL) begin
        done_o    = 1'b1;
        col_d     = '0;
        partial_d = '0;
      end else begin
        col_d     = col_q + COL_W'(1);
        partial_d = code;
      end
    end
  end

  assign code_o = code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      settle_q  <= '0;
      partial_q <= '0;
    end else if (advance_i) begin
      col_q     <= col_d;
      settle_q  <= settle_d;
      partial_q <= partial_d;
    end
  end

endmodule

### rtl/kmsd_debounce.sv
// Debouncer: raw code history, countdown and accepted key state.
module kmsd_debounce #(
  parameter int unsigned CODE_W = kmsd_pkg::ROWS_DEF * kmsd_pkg::COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic                            done_i,
  input  logic [CODE_W-1:0]               code_i,
  input  logic [kmsd_pkg::DEBOUNCE_W-1:0] debounce_ticks_i,
  output logic [CODE_W-1:0]               key_state_o,
  output logic [CODE_W-1:0]               prior_state_o,
  output kmsd_pkg::key_flags_t            flags_o
);
  import kmsd_pkg::*;

  logic [CODE_W-1:0]     raw_q, raw_d;
  logic [CODE_W-1:0]     acc_q, acc_d;
  logic [CODE_W-1:0]     prev_q, prev_d;
  logic [DEBOUNCE_W-1:0] cnt_q, cnt_d;
  logic [CODE_W-1:0]     diff;
  logic                  reload;

  always_comb begin
    raw_d   = raw_q;
    acc_d   = acc_q;
    prev_d  = prev_q;
    reload  = 1'b0;
    flags_o = '0;
    diff    = acc_q ^ code_i;
    if (done_i) begin
      if (code_i != raw_q) begin
        raw_d  = code_i;
        reload = 1'b1;
      end else if (code_i != acc_q && cnt_q == '0) begin
        prev_d           = acc_q;
        acc_d            = code_i;
        flags_o.changed  = 1'b1;
        flags_o.pressed  = |(code_i & diff);
        flags_o.released = |(acc_q & diff);
      end
    end
    // Reload on a raw change, else count down and hold at zero.
    if (reload) begin
      cnt_d = debounce_ticks_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DEBOUNCE_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign key_state_o   = acc_d;
  assign prior_state_o = prev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= '0;
      acc_q  <= '0;
      prev_q <= '0;
      cnt_q  <= DEBOUNCE_RESET;
    end else if (advance_i) begin
      raw_q  <= raw_d;
      acc_q  <= acc_d;
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/keypad_matrix_scan_debounce_top.sv
// The result of each accepted tick beat is registered in the output register.
// Throughput: one tick beat per cycle while results are read; a new beat is taken while the result is taken.
// The output register alone sets the rate: ready drops only while a result waits unread.
// Reset: asynchronous, active low; scan restarts at column 0, codes clear,
// settle_ticks returns to 1, debounce_ticks and the countdown to 20.
// Top level of the keypad matrix scanner with debounce.
module keypad_matrix_scan_debounce_top #(
  parameter int unsigned ROWS    = kmsd_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = kmsd_pkg::COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ROWS-1:0]                 row_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COLUMNS-1:0]              column_drive_o,
  output logic [ROWS*COLUMNS-1:0]         key_state_o,
  output logic [ROWS*COLUMNS-1:0]         prior_state_o,
  output logic                            scan_done_o,
  output logic                            state_changed_o,
  output logic                            key_pressed_o,
  output logic                            key_released_o
);
  import kmsd_pkg::*;

  localparam int unsigned CODE_W = ROWS * COLUMNS;

  logic [SETTLE_W-1:0]   settle_ticks_q;
  logic [DEBOUNCE_W-1:0] debounce_ticks_q;

  logic                  advance;
  logic                  out_valid_q;
  logic [COLUMNS-1:0]    drive;
  logic                  done;
  logic [CODE_W-1:0]     code;
  logic [CODE_W-1:0]     key_state;
  logic [CODE_W-1:0]     prior_state;
  key_flags_t            flags;

  logic [COLUMNS-1:0]    drive_q;
  logic [CODE_W-1:0]     key_state_q;
  logic [CODE_W-1:0]     prior_state_q;
  logic                  done_q;
  key_flags_t            flags_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign advance     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ticks_q   <= SETTLE_RESET;
      debounce_ticks_q <= DEBOUNCE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SETTLE_TICKS:   settle_ticks_q   <= cfg_data_i[SETTLE_W-1:0];
        CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  kmsd_scan #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .row_levels_i   (row_levels_i),
    .settle_ticks_i (settle_ticks_q),
    .column_drive_o (drive),
    .done_o         (done),
    .code_o         (code)
  );

  kmsd_debounce #(
    .CODE_W (CODE_W)
  ) u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .done_i           (done),
    .code_i           (code),
    .debounce_ticks_i (debounce_ticks_q),
    .key_state_o      (key_state),
    .prior_state_o    (prior_state),
    .flags_o          (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q       <= drive;
      key_state_q   <= key_state;
      prior_state_q <= prior_state;
      done_q        <= done;
      flags_q       <= flags;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign column_drive_o  = drive_q;
  assign key_state_o     = key_state_q;
  assign prior_state_o   = prior_state_q;
  assign scan_done_o     = done_q;
  assign state_changed_o = flags_q.changed;
  assign key_pressed_o   = flags_q.pressed;
  assign key_released_o  = flags_q.released;

endmodule
